// ===== rtl/dbis_pkg.sv =====
// ----------------------------------------------------------------------------
// dbis_pkg: shared types for the descending byte insertion sorter
// Holds the controller state encoding used by the top level.
// ----------------------------------------------------------------------------
package dbis_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

// ===== rtl/dbis_ram.sv =====
// ----------------------------------------------------------------------------
// dbis_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module dbis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold data when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/descending_byte_insertion_sort_top.sv =====
// ----------------------------------------------------------------------------
// descending_byte_insertion_sort_top: RAM-based descending insertion sorter
// Collects the bytes of a string, keeps them sorted largest first, and
// streams the sorted run out when the final byte arrives.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one byte per request, end_of_string
//   marks the final byte. in_ready is high only while the sorter is idle.
//   Output channel (out_valid/out_ready): the sorted run, largest first,
//   last_out on its final byte, overflowed on every byte of a run that lost
//   bytes beyond MAX_LEN.
//   Insertion walks the store from its tail towards the head, reading
//   through the RAM read port and shifting through its write port, one
//   entry per cycle, and stops below the first entry not smaller than the
//   byte. A byte that finds the store full is dropped and marks overflow.
//   After the final byte is placed, the first entry is read, then results
//   leave at one per cycle while out_ready stays high.
//   When the receiver stalls, the current result is held in the RAM read
//   register and nothing advances. No input is taken until the whole run
//   has been delivered.
//   Reset clears the fill count, the overflow flag and the controller; the
//   store contents are not cleared, since only written entries are read.
// ----------------------------------------------------------------------------
module descending_byte_insertion_sort_top
    import dbis_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       last_out,
    output logic       overflowed
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [7:0]      byte_reg, byte_next;
    logic            eos_reg, eos_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic            place_here;
    logic            is_last;

    dbis_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Stop the walk at the head or below an entry not smaller than the byte
    assign place_here = (pos_reg == '0) || (ram_rdata >= byte_reg);
    assign is_last    = (CW'(idx_reg) + CW'(1)) == fill_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        eos_reg  <= eos_next;
    end

    // Next state, RAM access and handshakes
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        eos_next   = eos_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    byte_next = char_in;
                    eos_next  = end_of_string;
                    if (fill_reg == CW'(MAX_LEN))
                    begin
                        // Drop the byte; the end mark still closes the string
                        ovf_next = 1'b1;
                        if (end_of_string)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                    else
                    begin
                        // Start the walk at the tail: read the last entry
                        pos_next   = fill_reg[AW-1:0];
                        ram_re     = (fill_reg != '0);
                        ram_raddr  = AW'(fill_reg - CW'(1));
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                if (place_here)
                begin
                    // Drop the byte into its slot and close the insertion
                    ram_wdata  = byte_reg;
                    fill_next  = fill_reg + CW'(1);
                    state_next = eos_reg ? ST_EMIT_RD : ST_IDLE;
                end
                else
                begin
                    // Move the smaller entry down one and read the next one up
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - AW'(1);
                    ram_re    = (pos_reg >= AW'(2));
                    ram_raddr = pos_reg - AW'(2);
                end
            end

            ST_EMIT_RD:
            begin
                idx_next   = '0;
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = ST_EMIT_OUT;
            end

            ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (is_last)
                    begin
                        // Clear for the next string
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Advance to the next entry
                        idx_next  = idx_reg + AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result payload
    assign char_out   = ram_rdata;
    assign last_out   = is_last;
    assign overflowed = ovf_reg;

endmodule

// ===== rtl/dbis_checker.sv =====
// ----------------------------------------------------------------------------
// dbis_checker: port-level checks for the descending insertion sorter
// Watches the top level's channels and flags ordering and handshake slips.
// ----------------------------------------------------------------------------
module dbis_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_in,
    input logic       end_of_string,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_out,
    input logic       last_out,
    input logic       overflowed
);

    logic out_take;
    logic in_take;

    assign out_take = out_valid && out_ready;
    assign in_take  = in_valid && in_ready;

    // Hold a waiting request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_in)
                                  && $stable(end_of_string))
        else $error("waiting request changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out)
                                    && $stable(last_out))
        else $error("stalled result changed");

    // Never take a request while a run is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_take && out_valid))
        else $error("request accepted during run output");

    // Within a run, bytes never increase
    a_descending: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !last_out |=> out_valid && (char_out <= $past(char_out)))
        else $error("sorted run not descending");

    // Overflow mark is constant across a run
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !last_out |=> $stable(overflowed))
        else $error("overflow mark changed within a run");

endmodule

bind descending_byte_insertion_sort_top dbis_checker u_dbis_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_in       (char_in),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_out      (char_out),
    .last_out      (last_out),
    .overflowed    (overflowed)
);
